FILE: rtl/core/lzw_pkg.sv
// ----------------------------------------------------------------------------
// lzw_pkg
// Shared types, sizes and helpers for the LZW byte compressor.
// ----------------------------------------------------------------------------
package lzw_pkg;

	localparam int CODE_BITS  = 12;
	localparam int NFC_BITS   = CODE_BITS + 1;
	localparam int BASE_CODES = 256;
	localparam int CODE_LIMIT = 1 << CODE_BITS;
	localparam int DICT_DEPTH = CODE_LIMIT - BASE_CODES;
	localparam int HASH_DEPTH = CODE_LIMIT;

	typedef logic [CODE_BITS-1:0] code_t;
	typedef logic [NFC_BITS-1:0]  nfc_t;
	typedef logic [7:0]           byte_t;

	// dictionary entry: the pair plus the hash slot that points at it
	typedef struct packed {
		code_t prefix;
		byte_t data;
		code_t slot;
	} dict_entry_t;

	localparam int ENTRY_BITS = $bits(dict_entry_t);

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_PROBE = 8'b0000_0100,
		ST_HREAD = 8'b0000_1000,
		ST_DREAD = 8'b0001_0000,
		ST_MISS  = 8'b0010_0000,
		ST_EMIT  = 8'b0100_0000,
		ST_FLUSH = 8'b1000_0000
	} state_t;

	// home slot of a (prefix, byte) pair
	function automatic code_t pair_hash(code_t prefix, byte_t data);
		code_t hi;
		hi = code_t'({data, {(CODE_BITS-8){1'b0}}});
		return prefix ^ hi ^ code_t'(data);
	endfunction

endpackage

FILE: rtl/core/lzw_if.sv
// ----------------------------------------------------------------------------
// lzw_in_if / lzw_out_if
// Valid/ready channels for uncompressed bytes and emitted codes.
// ----------------------------------------------------------------------------
interface lzw_in_if;
	logic               valid;
	logic               ready;
	logic [7:0]         data_byte;
	logic               end_of_string;

	modport source (output valid, output data_byte, output end_of_string, input ready);
	modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface lzw_out_if;
	logic                        valid;
	logic                        ready;
	logic [lzw_pkg::CODE_BITS-1:0] code;
	logic                        last_code;

	modport source (output valid, output code, output last_code, input ready);
	modport sink   (input valid, input code, input last_code, output ready);
endinterface

FILE: rtl/core/lzw_byte_compressor_top.sv
// A byte that starts a string is only accepted; any other byte is accepted, then each hash probe
// issues the slot read (PROBE) and takes the hash word (HREAD), plus a dictionary compare (DREAD)
// when the slot holds a candidate code; a miss adds an insert and an emit, end of string a flush.
// The input is ready only in IDLE, so a new byte is taken only once the last one is through; a
// full queue holds emit/flush.
// Reset: arst_n clears control state, then a clearing pass writes all 2^CODE_BITS hash slots.
// ----------------------------------------------------------------------------
// lzw_byte_compressor_top
// Streaming LZW compressor with a hashed dictionary held in two RAMs.
// ----------------------------------------------------------------------------
module lzw_byte_compressor_top (
	input logic   clk,
	input logic   arst_n,
	lzw_in_if.sink    in_chan,
	lzw_out_if.source out_chan
);
	import lzw_pkg::*;

	// Hash memory: slot -> code. Dictionary memory: code-256 -> pair and slot.
	// A slot is live only when its code is in [256, next free) and the
	// dictionary entry of that code points back at the same slot, so stale
	// slots from earlier strings never need clearing after the first pass.
	// A stale slot counts as free: the probe stops there and the pair goes in.
	state_t      state_q;
	nfc_t        nfc_q;
	code_t       prefix_q;
	logic        pv_q;
	byte_t       byte_q;
	logic        eos_q;
	code_t       slot_q;
	code_t       cand_q;

	logic        hash_we;
	code_t       hash_waddr;
	code_t       hash_wdata;
	code_t       hash_rdata;
	logic        dict_we;
	code_t       dict_waddr;
	dict_entry_t dict_wdata;
	code_t       dict_raddr;
	dict_entry_t dict_rdata;

	// two-entry result queue parts the core from the output side
	code_t       fifo_code_q [2];
	logic        fifo_last_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        push;
	logic        push_last;
	logic        pop;
	logic        room;
	logic        accept;
	logic        live;
	logic        owned;
	logic        match;
	logic        dict_open;

	lzw_ram #(.WIDTH(CODE_BITS), .DEPTH(HASH_DEPTH)) u_hash (
		.clk   (clk),
		.we    (hash_we),
		.waddr (hash_waddr),
		.wdata (hash_wdata),
		.raddr (slot_q),
		.rdata (hash_rdata)
	);

	lzw_ram #(.WIDTH(ENTRY_BITS), .DEPTH(DICT_DEPTH)) u_dict (
		.clk   (clk),
		.we    (dict_we),
		.waddr (dict_waddr),
		.wdata (dict_wdata),
		.raddr (dict_raddr),
		.rdata (dict_rdata)
	);

	assign room      = (cnt_q != 2'd2);
	assign accept    = in_chan.valid && in_chan.ready;
	assign pop       = out_chan.valid && out_chan.ready;
	assign dict_open = (nfc_q < nfc_t'(CODE_LIMIT));

	assign in_chan.ready  = (state_q == ST_IDLE);
	assign out_chan.valid = (cnt_q != 2'd0);
	assign out_chan.code      = fifo_code_q[rd_ptr_q];
	assign out_chan.last_code = fifo_last_q[rd_ptr_q];

	// candidate code read from the hash slot is live in this string
	assign live = (hash_rdata >= code_t'(BASE_CODES)) && (nfc_t'(hash_rdata) < nfc_q);
	assign dict_raddr = hash_rdata - code_t'(BASE_CODES);

	// the candidate's entry points back at this slot
	assign owned = (dict_rdata.slot == slot_q);
	assign match = owned && (dict_rdata.prefix == prefix_q)
		&& (dict_rdata.data == byte_q);

	always_comb begin
		hash_we    = 1'b0;
		hash_waddr = slot_q;
		hash_wdata = '0;
		dict_we    = 1'b0;
		dict_waddr = code_t'(nfc_q - nfc_t'(BASE_CODES));
		dict_wdata = '{prefix: prefix_q, data: byte_q, slot: slot_q};
		push       = 1'b0;
		push_last  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				hash_we = 1'b1;
			end
			ST_MISS: begin
				// add the pair while codes remain
				hash_we    = dict_open;
				hash_wdata = code_t'(nfc_q);
				dict_we    = dict_open;
			end
			ST_EMIT: begin
				push = room;
			end
			ST_FLUSH: begin
				push      = room;
				push_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			nfc_q    <= nfc_t'(BASE_CODES);
			prefix_q <= '0;
			pv_q     <= 1'b0;
			slot_q   <= '0;
			cand_q   <= '0;
			eos_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					// sweep every hash slot once after reset
					slot_q <= slot_q + code_t'(1);
					if (slot_q == code_t'(HASH_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						eos_q <= in_chan.end_of_string;
						if (!pv_q) begin
							// no prefix held: the byte starts one
							prefix_q <= code_t'(in_chan.data_byte);
							pv_q     <= 1'b1;
							state_q  <= in_chan.end_of_string ? ST_FLUSH : ST_IDLE;
						end else begin
							slot_q  <= pair_hash(prefix_q, in_chan.data_byte);
							state_q <= ST_PROBE;
						end
					end
				end
				ST_PROBE: begin
					state_q <= ST_HREAD;
				end
				ST_HREAD: begin
					cand_q  <= hash_rdata;
					state_q <= live ? ST_DREAD : ST_MISS;
				end
				ST_DREAD: begin
					if (match) begin
						// extend the prefix, emit nothing
						prefix_q <= cand_q;
						state_q  <= eos_q ? ST_FLUSH : ST_IDLE;
					end else if (owned) begin
						slot_q  <= slot_q + code_t'(1);
						state_q <= ST_PROBE;
					end else begin
						// stale slot: take it for the new pair
						state_q <= ST_MISS;
					end
				end
				ST_MISS: begin
					if (dict_open) begin
						nfc_q <= nfc_q + nfc_t'(1);
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (room) begin
						prefix_q <= code_t'(byte_q);
						state_q  <= eos_q ? ST_FLUSH : ST_IDLE;
					end
				end
				ST_FLUSH: begin
					if (room) begin
						nfc_q    <= nfc_t'(BASE_CODES);
						prefix_q <= '0;
						pv_q     <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// hold the byte of the item in flight and write pushed codes into the queue
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= in_chan.data_byte;
		end
		if (push) begin
			fifo_code_q[wr_ptr_q] <= prefix_q;
			fifo_last_q[wr_ptr_q] <= push_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// next free code stays within the code space
	a_nfc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(nfc_q >= nfc_t'(BASE_CODES)) && (nfc_q <= nfc_t'(CODE_LIMIT)))
		else $error("next free code out of range");

	// a transfer into the queue never overruns it
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != 2'd2))
		else $error("result queue overrun");

	// dictionary compare only follows a hash read
	a_dread_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DREAD) |-> ($past(state_q) == ST_HREAD))
		else $error("dictionary read without hash read");

	// nothing is emitted during the clearing pass
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (cnt_q == 2'd0))
		else $error("result during clearing pass");

endmodule

FILE: rtl/core/lzw_ram.sv
// ----------------------------------------------------------------------------
// lzw_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module lzw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: bench/tb_lzw_byte_compressor_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lzw_byte_compressor_top
// Self-checking bench: strings of bytes are offered on the input channel, an
// LZW model in the bench predicts the emitted codes, and every code transfer
// is compared against the oldest prediction. Idling on both sides varies by
// phase, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_lzw_byte_compressor_top;
	import lzw_pkg::*;

	typedef struct {
		byte_t data;
		bit    eos;
	} byte_item_t;

	typedef struct {
		code_t code;
		bit    last;
	} code_item_t;

	logic clk;
	logic arst_n;

	lzw_in_if  in_bus ();
	lzw_out_if out_bus ();

	lzw_byte_compressor_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_chan  (in_bus),
		.out_chan (out_bus)
	);

	// bytes waiting to be offered, codes waiting to be seen
	byte_item_t bytes_to_send[$];
	code_item_t codes_due[$];

	// model state: pair {prefix, byte} -> code
	code_t      pair_codes[bit [CODE_BITS+7:0]];
	nfc_t       free_code;
	code_t      cur_prefix;
	bit         have_prefix;

	int         errors;
	int         send_idle_pct;
	int         recv_stall_pct;
	int         hold_cycles;

	always #2 clk = ~clk;

	// Work out the codes one accepted byte causes and queue them.
	task automatic predict_codes(input byte_t b, input bit eos);
		bit [CODE_BITS+7:0] key;
		code_item_t         ci;
		if (!have_prefix) begin
			cur_prefix  = code_t'(b);
			have_prefix = 1'b1;
		end else begin
			key = {cur_prefix, b};
			if (pair_codes.exists(key)) begin
				cur_prefix = pair_codes[key];
			end else begin
				ci.code = cur_prefix;
				ci.last = 1'b0;
				codes_due = {codes_due, ci};
				// stop adding once every code is taken
				if (free_code < nfc_t'(CODE_LIMIT)) begin
					pair_codes[key] = code_t'(free_code);
					free_code++;
				end
				cur_prefix = code_t'(b);
			end
		end
		if (eos) begin
			ci.code = cur_prefix;
			ci.last = 1'b1;
			codes_due = {codes_due, ci};
			pair_codes.delete();
			free_code   = nfc_t'(BASE_CODES);
			cur_prefix  = '0;
			have_prefix = 1'b0;
		end
	endtask

	// Queue one string; alph of zero means the full byte range.
	task automatic add_string(input int len, input int alph);
		byte_item_t it;
		int         base;
		base = $urandom_range(0, 255);
		for (int i = 0; i < len; i++) begin
			if (alph == 0)
				it.data = byte_t'($urandom);
			else
				it.data = byte_t'(base + $urandom_range(0, alph - 1));
			it.eos = (i == len - 1);
			bytes_to_send = {bytes_to_send, it};
		end
	endtask

	task automatic add_byte(input int b, input bit eos);
		byte_item_t it;
		it.data = byte_t'(b);
		it.eos  = eos;
		bytes_to_send = {bytes_to_send, it};
	endtask

	// Hold until every byte is taken and every predicted code has come.
	task automatic drain();
		while (bytes_to_send.size() != 0 || in_bus.valid || codes_due.size() != 0)
			@(posedge clk);
	endtask

	// Driver: advance to the next byte only after a transfer or while idle.
	always @(posedge clk) begin
		if (arst_n && (!in_bus.valid || in_bus.ready)) begin
			if (bytes_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				in_bus.valid         <= 1'b1;
				in_bus.data_byte     <= bytes_to_send[0].data;
				in_bus.end_of_string <= bytes_to_send[0].eos;
				bytes_to_send.pop_front();
			end else begin
				in_bus.valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, or a counted hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_bus.ready <= 1'b0;
			hold_cycles   <= hold_cycles - 1;
		end else begin
			out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Monitor: predict on each byte transfer, check each code transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_bus.valid && in_bus.ready)
				predict_codes(in_bus.data_byte, in_bus.end_of_string);
			if (out_bus.valid && out_bus.ready) begin
				if (codes_due.size() == 0) begin
					$error("unexpected code %0d last_code %0b", out_bus.code, out_bus.last_code);
					errors++;
				end else begin
					if (out_bus.code !== codes_due[0].code) begin
						$error("code: expected %0d, got %0d", codes_due[0].code, out_bus.code);
						errors++;
					end
					if (out_bus.last_code !== codes_due[0].last) begin
						$error("last_code: expected %0b, got %0b", codes_due[0].last,
							out_bus.last_code);
						errors++;
					end
					codes_due.pop_front();
				end
			end
		end
	end

	initial begin
		clk                  = 1'b0;
		arst_n               = 1'b0;
		in_bus.valid         = 1'b0;
		in_bus.data_byte     = '0;
		in_bus.end_of_string = 1'b0;
		out_bus.ready        = 1'b0;
		errors               = 0;
		send_idle_pct        = 0;
		recv_stall_pct       = 0;
		hold_cycles          = 0;
		free_code            = nfc_t'(BASE_CODES);
		cur_prefix           = '0;
		have_prefix          = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: lone byte, extremes, prefix extension, miss then flush
		add_byte(0, 1'b1);
		add_byte(255, 1'b1);
		add_byte(0, 1'b0);
		add_byte(255, 1'b1);
		for (int i = 0; i < 8; i++)
			add_byte(8'hAA, i == 7);
		add_byte(8'h55, 1'b0);
		add_byte(8'h55, 1'b0);
		add_byte(8'h55, 1'b0);
		add_byte(8'h0F, 1'b0);
		add_byte(8'hF0, 1'b0);
		add_byte(8'h55, 1'b0);
		add_byte(8'h55, 1'b0);
		add_byte(8'h0F, 1'b1);
		drain();

		// no idling
		for (int s = 0; s < 10; s++)
			add_string($urandom_range(1, 30), $urandom_range(1, 6));
		drain();

		// sender idle most of the time
		send_idle_pct = 77;
		for (int s = 0; s < 10; s++)
			add_string($urandom_range(1, 30), $urandom_range(1, 6));
		drain();

		// receiver stalling most of the time
		send_idle_pct  = 0;
		recv_stall_pct = 77;
		for (int s = 0; s < 10; s++)
			add_string($urandom_range(1, 30), $urandom_range(1, 6));
		drain();

		// long hold-off while bytes keep coming, so the input backs up
		recv_stall_pct = 0;
		hold_cycles    = 3000;
		for (int s = 0; s < 6; s++)
			add_string($urandom_range(20, 40), $urandom_range(2, 8));
		drain();

		// light idling on both sides, with some full-range noise strings
		send_idle_pct  = 8;
		recv_stall_pct = 8;
		for (int s = 0; s < 12; s++)
			add_string($urandom_range(1, 30), ($urandom_range(0, 3) == 0) ? 0 : 4);
		drain();

		// mixed tail
		for (int s = 0; s < 10; s++)
			add_string($urandom_range(1, 20), $urandom_range(1, 3));
		drain();

		repeat (64) @(posedge clk);
		if (errors == 0)
			$display("tb_lzw_byte_compressor_top: done, clean");
		else
			$display("tb_lzw_byte_compressor_top: done, errors");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("tb_lzw_byte_compressor_top: done, errors");
		$finish;
	end

endmodule
